// ===== design/ipcidr_pkg.sv =====
// Shared types, constants and helpers for the IPv4 CIDR text parser.
// No dependencies; used by ipcidr_step and ipv4_cidr_text_parser.
`timescale 1ns / 1ps

package ipcidr_pkg;

    localparam int unsigned KwLen     = 7;
    localparam int unsigned PrefixSat = 33;
    localparam int unsigned MaxPrefix = 32;
    localparam int unsigned MaxOctet  = 255;
    localparam int unsigned MaxDigits = 3;
    localparam int unsigned LastOctet = 3;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChSlash = 8'h2F;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_KEYWORD = 3'd1,
        PH_OCTET   = 3'd2,
        PH_SLASH   = 3'd3,
        PH_PREFIX  = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  octet_index;
        logic [8:0]  octet_value;
        logic [1:0]  digit_count;
        logic [31:0] address_shift;
        logic [5:0]  prefix_accum;
        logic [2:0]  keyword_pos;
        logic        error_seen;
    } t_parse_state;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
        logic [5:0]  prefix_length;
        logic [31:0] mask_word;
    } t_result;

    localparam t_parse_state StateReset = '{
        phase:         PH_START,
        octet_index:   2'd0,
        octet_value:   9'd0,
        digit_count:   2'd0,
        address_shift: 32'd0,
        prefix_accum:  6'd0,
        keyword_pos:   3'd0,
        error_seen:    1'b0
    };

    // Letters of the keyword "default", by position.
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                3'd0:    c = 8'h64; // d
                3'd1:    c = 8'h65; // e
                3'd2:    c = 8'h66; // f
                3'd3:    c = 8'h61; // a
                3'd4:    c = 8'h75; // u
                3'd5:    c = 8'h6C; // l
                3'd6:    c = 8'h74; // t
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== design/ipv4_cidr_text_parser.sv =====
// Top level of the streaming IPv4 CIDR text parser: input register,
// parse state, result register. Depends on ipcidr_pkg and ipcidr_step.
`timescale 1ns / 1ps
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | i_valid / o_ready  | i_character, i_final_char
//  result   | o_valid / i_ready  | o_valid_res, o_address, o_prefix_length,
//           |                    | o_mask_word
//
// One character per cycle, while no last character is held back by a stalled
// result. Each character is held in the input register, where the parse step
// updates the state; a last character then loads the result register.
// Reset clears the parse state and both valid flags.
// A stalled result holds only a last character behind it; other characters
// keep flowing through the state while the result waits.

module ipv4_cidr_text_parser
    import ipcidr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_character,
    input  logic        i_final_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_valid_res,
    output logic [31:0] o_address,
    output logic [5:0]  o_prefix_length,
    output logic [31:0] o_mask_word
);

    logic         r_in_valid;
    logic [7:0]   r_char;
    logic         r_last;
    t_parse_state r_state;
    logic         r_out_valid;
    t_result      r_out;

    t_parse_state w_next;
    t_result      w_result;
    logic         w_advance;

    ipcidr_step u_step (
        .i_state     (r_state),
        .i_character (r_char),
        .o_next      (w_next),
        .o_result    (w_result)
    );

    // a non-final character never needs the result slot
    assign w_advance = r_in_valid && (!r_last || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_character;
            r_last <= i_final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (w_advance) begin
            r_state <= r_last ? StateReset : w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_last) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_valid_res     = r_out.valid_res;
    assign o_address       = r_out.address;
    assign o_prefix_length = r_out.prefix_length;
    assign o_mask_word     = r_out.mask_word;

endmodule

// ===== design/ipcidr_step.sv =====
// Per-character parse step: next state from current state and one character,
// plus the result that the string would give if this character is its last.
// Depends on ipcidr_pkg.
`timescale 1ns / 1ps

module ipcidr_step
    import ipcidr_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_character,
    output t_parse_state o_next,
    output t_result      o_result
);

    logic         w_digit;
    logic [3:0]   w_dval;
    logic [11:0]  w_octet_v;
    logic [8:0]   w_prefix_v;
    t_parse_state w_cons;

    assign w_digit    = (i_character >= ChZero) && (i_character <= ChNine);
    assign w_dval     = 4'(i_character - ChZero);
    assign w_octet_v  = 12'(i_state.octet_value) * 12'd10 + 12'(w_dval);
    assign w_prefix_v = 9'(i_state.prefix_accum) * 9'd10 + 9'(w_dval);

    // Next phase and fields after consuming the character.
    always_comb begin
        w_cons = i_state;
        if (!i_state.error_seen) begin
            unique case (i_state.phase)
                PH_START: begin
                    if (i_character == kw_char(3'd0)) begin
                        w_cons.keyword_pos = 3'd1;
                        w_cons.phase       = PH_KEYWORD;
                    end else if (w_digit) begin
                        w_cons.octet_value = 9'(w_dval);
                        w_cons.digit_count = 2'd1;
                        w_cons.phase       = PH_OCTET;
                    end else begin
                        w_cons.error_seen = 1'b1;
                    end
                end
                PH_KEYWORD: begin
                    if (i_state.keyword_pos < 3'(KwLen)
                            && i_character == kw_char(i_state.keyword_pos)) begin
                        w_cons.keyword_pos = i_state.keyword_pos + 3'd1;
                    end else begin
                        w_cons.error_seen = 1'b1;
                    end
                end
                PH_OCTET: begin
                    if (w_digit) begin
                        if (i_state.digit_count >= 2'(MaxDigits)
                                || w_octet_v > 12'(MaxOctet)) begin
                            w_cons.error_seen = 1'b1;
                        end else begin
                            w_cons.octet_value = w_octet_v[8:0];
                            w_cons.digit_count = i_state.digit_count + 2'd1;
                        end
                    end else if (i_character == ChDot) begin
                        if (i_state.digit_count == 2'd0
                                || i_state.octet_index == 2'(LastOctet)) begin
                            w_cons.error_seen = 1'b1;
                        end else begin
                            w_cons.address_shift = {i_state.address_shift[23:0],
                                                    i_state.octet_value[7:0]};
                            w_cons.octet_index   = i_state.octet_index + 2'd1;
                            w_cons.octet_value   = 9'd0;
                            w_cons.digit_count   = 2'd0;
                        end
                    end else if (i_character == ChSlash) begin
                        if (i_state.digit_count == 2'd0
                                || i_state.octet_index != 2'(LastOctet)) begin
                            w_cons.error_seen = 1'b1;
                        end else begin
                            w_cons.address_shift = {i_state.address_shift[23:0],
                                                    i_state.octet_value[7:0]};
                            w_cons.phase         = PH_SLASH;
                        end
                    end else begin
                        w_cons.error_seen = 1'b1;
                    end
                end
                PH_SLASH, PH_PREFIX: begin
                    if (w_digit) begin
                        // saturate so that overflow stays detectable
                        w_cons.prefix_accum = (w_prefix_v > 9'(PrefixSat))
                                              ? 6'(PrefixSat) : w_prefix_v[5:0];
                        w_cons.phase        = PH_PREFIX;
                    end else begin
                        w_cons.error_seen = 1'b1;
                    end
                end
                default: begin
                    w_cons.error_seen = 1'b1;
                end
            endcase
        end
    end

    assign o_next = w_cons;

    // Result as seen after this character.
    always_comb begin
        logic [31:0] addr;
        logic [5:0]  plen;
        logic        ok;
        ok   = 1'b0;
        addr = 32'd0;
        plen = 6'd0;
        if (!w_cons.error_seen) begin
            priority if (w_cons.phase == PH_KEYWORD && w_cons.keyword_pos == 3'(KwLen)) begin
                ok = 1'b1;
            end else if (w_cons.phase == PH_OCTET && w_cons.digit_count != 2'd0
                         && w_cons.octet_index == 2'(LastOctet)) begin
                ok   = 1'b1;
                addr = {w_cons.address_shift[23:0], w_cons.octet_value[7:0]};
                plen = 6'(MaxPrefix);
            end else if (w_cons.phase == PH_PREFIX
                         && w_cons.prefix_accum <= 6'(MaxPrefix)) begin
                ok   = 1'b1;
                addr = w_cons.address_shift;
                plen = w_cons.prefix_accum;
            end else begin
                ok = 1'b0;
            end
        end
        o_result.valid_res     = ok;
        o_result.address       = addr;
        o_result.prefix_length = plen;
        for (int k = 0; k < 32; k++) begin
            o_result.mask_word[31 - k] = (6'(k) < plen);
        end
    end

endmodule
